// ----- src/rp50_pkg.sv -----
// Shared types, constants and digit helpers for the Radix-50 packer and unpacker.
package rp50_pkg;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 88;

	localparam logic KIND_ENCODE = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	localparam logic [5:0] NO_DIGIT = 6'h3F;
	localparam logic [5:0] RADIX    = 6'd40;
	localparam logic [2:0] MAX_DIGITS = 3'd6;

	localparam logic [31:0] POW40 [7] = '{
		32'd1, 32'd40, 32'd1600, 32'd64000, 32'd2560000, 32'd102400000, 32'd4096000000
	};

	localparam logic [6:0] CHAR_TAB [40] = '{
		7'h20, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45,
		7'h46, 7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D,
		7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55,
		7'h56, 7'h57, 7'h58, 7'h59, 7'h5A, 7'h2E, 7'h24, 7'h25
	};

	typedef struct packed {
		logic        kind;
		logic        last;
		logic [5:0]  dig;
		logic [3:0]  code;
		logic [31:0] word;
	} req_t;

	typedef struct packed {
		logic            vld;
		logic            kind;
		logic [3:0]      code;
		logic [2:0]      cnt;
		logic [31:0]     x;
		logic [5:0]      lo;
		logic [5:0][5:0] dig;
	} stage_t;

	typedef struct packed {
		logic            vld;
		logic            kind;
		logic [35:0]     packed_out;
		logic [5:0]      code_out;
		logic [5:0][6:0] chr;
	} out_t;

	function automatic logic [5:0] char_to_digit(input logic [6:0] c);
		logic [5:0] d;
		d = NO_DIGIT;
		if (c == 7'h20) begin
			d = 6'd0;
		end else if (c >= 7'h30 && c <= 7'h39) begin
			d = 6'(c - 7'h2F);
		end else if (c >= 7'h41 && c <= 7'h5A) begin
			d = 6'(c - 7'h36);
		end else if (c >= 7'h61 && c <= 7'h7A) begin
			d = 6'(c - 7'h56);
		end else if (c == 7'h2E) begin
			d = 6'd37;
		end else if (c == 7'h24) begin
			d = 6'd38;
		end else if (c == 7'h25) begin
			d = 6'd39;
		end
		return d;
	endfunction

	function automatic logic [6:0] digit_to_char(input logic [5:0] d);
		logic [6:0] c;
		c = CHAR_TAB[0];
		if (d < RADIX) begin
			c = CHAR_TAB[d];
		end
		return c;
	endfunction

	// v / 40 as (v >> 3) / 5 by reciprocal multiply
	function automatic logic [31:0] div40(input logic [31:0] v);
		logic [60:0] p;
		p = 61'(v[31:3]) * 61'(32'hCCCC_CCCD);
		return 32'(p[60:34]);
	endfunction

	// low digit of v given low bits of v and of v / 40
	function automatic logic [5:0] rem40(input logic [5:0] vlo, input logic [5:0] qlo);
		return 6'(vlo - {qlo[0], 5'b0} - {qlo[2:0], 3'b0});
	endfunction

	function automatic logic [5:0] mod40(input logic [5:0] v);
		return (v >= RADIX) ? 6'(v - RADIX) : v;
	endfunction

endpackage

// ----- src/radix50_pack_unpack.sv -----
// Radix-50 36-bit word packer and unpacker, top level.
//
// Input stream s_*: one request per accepted transfer. s_tuser selects the
// operation (0 = encode one character, 1 = decode one packed word); s_tlast
// marks the final character of a symbol. An encode request without s_tlast
// updates the running symbol and yields no result.
// Output stream m_*: one result per decode request and per last-flagged
// encode request, in request order. m_tuser gives the result kind.
// A request passes through the queue entry, six execution stages (a divide
// by 40 ahead of every stage but the first, for the digits) and the result
// register before its result appears on m_tvalid.
// Throughput: one request per cycle, sustained while m_tready stays high.
// When the receiver stalls, the result register and execution stages hold,
// the request queue fills, and s_tready drops once QUEUE_DEPTH requests wait.
// Reset clears the symbol accumulator, the queue and all stage valid bits.
module radix50_pack_unpack #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// char_in[7:0], code_bits[13:8], packed_in[49:14], zero[55:50]
	input  logic [rp50_pkg::S_TDATA_W-1:0] s_tdata,
	// action
	input  logic                           s_tuser,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// packed_out[35:0], code_out[41:36], char_first[48:42], char_second[55:49],
	// char_third[62:56], char_fourth[69:63], char_fifth[76:70],
	// char_sixth[83:77], zero[87:84]
	output logic [rp50_pkg::M_TDATA_W-1:0] m_tdata,
	// result_kind
	output logic                           m_tuser
);

	logic           push;
	logic           full;
	logic           q_vld;
	logic           pop;
	rp50_pkg::req_t push_req;
	rp50_pkg::req_t q_req;

	rp50_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.full     (full),
		.push     (push),
		.push_req (push_req)
	);

	rp50_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.full     (full),
		.q_vld    (q_vld),
		.q_req    (q_req),
		.pop      (pop)
	);

	rp50_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_vld    (q_vld),
		.q_req    (q_req),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- src/rp50_front.sv -----
// Request intake: unpacks the input stream and maps characters to digits.
module rp50_front (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rp50_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	input  logic                           s_tlast,
	input  logic                           full,
	output logic                           push,
	output rp50_pkg::req_t                 push_req
);

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		push_req      = '0;
		push_req.kind = s_tuser;
		push_req.last = s_tlast;
		push_req.dig  = rp50_pkg::char_to_digit(s_tdata[6:0]);
		push_req.word = s_tdata[45:14];
		if (s_tuser == rp50_pkg::KIND_DECODE) begin
			push_req.code = s_tdata[49:46];
		end else begin
			push_req.code = s_tdata[13:10];
		end
	end

endmodule

// ----- src/rp50_fifo.sv -----
// Short request queue between intake and execution.
module rp50_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rp50_pkg::req_t push_req,
	output logic           full,
	output logic           q_vld,
	output rp50_pkg::req_t q_req,
	input  logic           pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	rp50_pkg::req_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign q_vld = (cnt_q != '0);
	assign q_req = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

// ----- src/rp50_back.sv -----
// Execution pipeline: encoder accumulation, padding, digit extraction and result register.
module rp50_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_vld,
	input  rp50_pkg::req_t                 q_req,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rp50_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser
);

	logic [31:0] acc_q;
	logic [2:0]  cnt_q;
	logic        stop_q;

	logic [31:0] acc_nx;
	logic [2:0]  cnt_nx;
	logic        stop_nx;
	logic        take;
	logic        en;

	rp50_pkg::stage_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	rp50_pkg::stage_t nx_s1, nx_s2, nx_s3, nx_s4, nx_s5, nx_s6;
	rp50_pkg::out_t   out_q, nx_out;
	logic [5:0][5:0]  dg_last;

	function automatic rp50_pkg::stage_t step(input rp50_pkg::stage_t p,
			input logic [2:0] idx);
		rp50_pkg::stage_t r;
		r = p;
		if (p.kind == rp50_pkg::KIND_DECODE) begin
			r.x        = rp50_pkg::div40(p.x);
			r.lo       = p.x[5:0];
			r.dig[idx] = rp50_pkg::rem40(p.lo, p.x[5:0]);
		end
		return r;
	endfunction

	assign en       = !out_q.vld || m_tready;
	assign pop      = en && q_vld;
	assign m_tvalid = out_q.vld;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {4'b0, out_q.chr, out_q.code_out, out_q.packed_out};

	always_comb begin
		acc_nx  = acc_q;
		cnt_nx  = cnt_q;
		stop_nx = stop_q;
		take    = !stop_q && (cnt_q < rp50_pkg::MAX_DIGITS);
		if (take) begin
			if (q_req.dig == rp50_pkg::NO_DIGIT) begin
				stop_nx = 1'b1;
			end else begin
				acc_nx = {acc_q[26:0], 5'b0} + {acc_q[28:0], 3'b0} + {26'b0, q_req.dig};
				cnt_nx = 3'(cnt_q + 3'd1);
			end
		end

		nx_s1      = '0;
		nx_s1.vld  = pop && (q_req.kind == rp50_pkg::KIND_DECODE || q_req.last);
		nx_s1.kind = q_req.kind;
		nx_s1.code = q_req.code;
		if (q_req.kind == rp50_pkg::KIND_DECODE) begin
			nx_s1.x = q_req.word;
		end else begin
			nx_s1.x   = acc_nx;
			nx_s1.cnt = cnt_nx;
		end
	end

	always_comb begin
		nx_s2 = st_s1;
		if (st_s1.kind == rp50_pkg::KIND_DECODE) begin
			nx_s2.x  = rp50_pkg::div40(st_s1.x);
			nx_s2.lo = st_s1.x[5:0];
		end else begin
			nx_s2.x = st_s1.x * rp50_pkg::POW40[3'(rp50_pkg::MAX_DIGITS - st_s1.cnt)];
		end
		nx_s3 = step(st_s2, 3'd5);
		nx_s4 = step(st_s3, 3'd4);
		nx_s5 = step(st_s4, 3'd3);
		nx_s6 = step(st_s5, 3'd2);
	end

	always_comb begin
		dg_last    = st_s6.dig;
		dg_last[1] = rp50_pkg::rem40(st_s6.lo, st_s6.x[5:0]);
		dg_last[0] = rp50_pkg::mod40(st_s6.x[5:0]);

		nx_out      = '0;
		nx_out.vld  = st_s6.vld;
		nx_out.kind = st_s6.kind;
		if (st_s6.kind == rp50_pkg::KIND_DECODE) begin
			nx_out.code_out = {st_s6.code, 2'b00};
			for (int i = 0; i < 6; i++) begin
				nx_out.chr[i] = rp50_pkg::digit_to_char(dg_last[i]);
			end
		end else begin
			nx_out.packed_out = {st_s6.code, st_s6.x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			stop_q <= 1'b0;
		end else if (pop && q_req.kind == rp50_pkg::KIND_ENCODE) begin
			if (q_req.last) begin
				acc_q  <= '0;
				cnt_q  <= '0;
				stop_q <= 1'b0;
			end else begin
				acc_q  <= acc_nx;
				cnt_q  <= cnt_nx;
				stop_q <= stop_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
			st_s2 <= '0;
			st_s3 <= '0;
			st_s4 <= '0;
			st_s5 <= '0;
			st_s6 <= '0;
			out_q <= '0;
		end else if (en) begin
			st_s1 <= nx_s1;
			st_s2 <= nx_s2;
			st_s3 <= nx_s3;
			st_s4 <= nx_s4;
			st_s5 <= nx_s5;
			st_s6 <= nx_s6;
			out_q <= nx_out;
		end
	end

endmodule
